// File: design/pf_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package pf_pkg;

    localparam int NUMBER_W        = 32;
    localparam int POSITION_W      = 5;
    localparam int VALUE_WIDTH_DEF = 32;

    typedef struct packed {
        logic done;
        logic exact;
    } div_status_t;

endpackage

`default_nettype wire

// File: design/pf_divider.sv
`timescale 1ns / 1ps
`default_nettype none

module pf_divider
    import pf_pkg::*;
#(
    parameter int W = VALUE_WIDTH_DEF
)
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         start,
    input  wire logic [W-1:0] dividend,
    input  wire logic [W-1:0] divisor,
    output logic      [W-1:0] quotient,
    output div_status_t       status
);

    localparam int CNTW = $clog2(W + 1);

    logic [W-1:0]    quo_reg, quo_next;
    logic [W-1:0]    rem_reg, rem_next;
    logic [CNTW-1:0] cnt_reg, cnt_next;
    logic            busy_reg, busy_next;
    logic            done_reg, done_next;
    logic [W:0]      trial;
    logic            fits;

    // one quotient bit per cycle, restoring
    assign trial = {rem_reg, quo_reg[W-1]};
    assign fits  = (trial >= {1'b0, divisor});

    always_comb
    begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            quo_next  = dividend;
            rem_next  = '0;
            cnt_next  = CNTW'(W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (fits)
                rem_next = W'(trial - {1'b0, divisor});
            else
                rem_next = trial[W-1:0];
            quo_next = {quo_reg[W-2:0], fits};
            cnt_next = cnt_reg - CNTW'(1);
            if (cnt_reg == CNTW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
    end

    assign quotient     = quo_reg;
    assign status.done  = done_reg;
    assign status.exact = (rem_reg == '0);

endmodule

`default_nettype wire

// File: design/prime_factorizer_top.sv
// Trial division: divisor 2, then odd values up to the square root of the remaining
// value, each trial run through the one bit-serial divider shared by every trial.
// Throughput: one item at a time; busy stays high until the last result is out.
// Results leave one per cycle at most on valid; the receiver cannot stall.
// Reset: asynchronous, active low; returns to idle with no result pending.
`timescale 1ns / 1ps
`default_nettype none

module prime_factorizer_top
    import pf_pkg::*;
#(
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  start,
    output logic                       busy,
    input  wire logic [NUMBER_W-1:0]   number,
    output logic                       valid,
    output logic      [NUMBER_W-1:0]   factor,
    output logic      [POSITION_W-1:0] position,
    output logic                       last
);

    localparam int VW = VALUE_WIDTH;
    localparam int SW = VALUE_WIDTH + 2;
    localparam int CW = (VALUE_WIDTH < NUMBER_W) ? VALUE_WIDTH : NUMBER_W;

    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_CHECK  = 5'b00010,
        ST_DIVIDE = 5'b00100,
        ST_FINISH = 5'b01000,
        ST_LAST   = 5'b10000
    } state_t;

    state_t                state_reg, state_next;
    logic [VW-1:0]         rem_reg, rem_next;
    logic [VW-1:0]         d_reg, d_next;
    logic [SW-1:0]         sq_reg, sq_next;
    logic [VW-1:0]         pend_reg, pend_next;
    logic                  pend_valid_reg, pend_valid_next;
    logic [POSITION_W-1:0] count_reg, count_next;
    logic                  valid_reg, valid_next;
    logic [NUMBER_W-1:0]   factor_reg, factor_next;
    logic [POSITION_W-1:0] position_reg, position_next;
    logic                  last_reg, last_next;

    logic [VW-1:0]         number_masked;
    logic                  div_start;
    logic [VW-1:0]         div_quotient;
    div_status_t           div_status;

    assign number_masked = VW'(number[CW-1:0]);
    assign div_start     = (state_reg == ST_CHECK) && (sq_reg <= {2'b00, rem_reg});

    pf_divider #(
        .W (VW)
    ) u_divider (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (rem_reg),
        .divisor  (d_reg),
        .quotient (div_quotient),
        .status   (div_status)
    );

    always_comb
    begin
        state_next      = state_reg;
        rem_next        = rem_reg;
        d_next          = d_reg;
        sq_next         = sq_reg;
        pend_next       = pend_reg;
        pend_valid_next = pend_valid_reg;
        count_next      = count_reg;
        valid_next      = 1'b0;
        factor_next     = factor_reg;
        position_next   = position_reg;
        last_next       = last_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    rem_next        = number_masked;
                    d_next          = VW'(2);
                    sq_next         = SW'(4);
                    pend_valid_next = 1'b0;
                    count_next      = '0;
                    if (number_masked >= VW'(2))
                        state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                if (sq_reg <= {2'b00, rem_reg})
                    state_next = ST_DIVIDE;
                else
                    state_next = ST_FINISH;
            end
            ST_DIVIDE:
            begin
                if (div_status.done)
                begin
                    if (div_status.exact)
                    begin
                        rem_next = div_quotient;
                        // hold the newest factor back: last and the prime case depend on it
                        if (pend_valid_reg)
                        begin
                            valid_next    = 1'b1;
                            factor_next   = NUMBER_W'(pend_reg);
                            position_next = count_reg;
                            last_next     = 1'b0;
                            count_next    = count_reg + POSITION_W'(1);
                        end
                        pend_next       = d_reg;
                        pend_valid_next = 1'b1;
                    end
                    else if (d_reg == VW'(2))
                    begin
                        d_next  = VW'(3);
                        sq_next = SW'(9);
                    end
                    else
                    begin
                        // skip even divisors: (d + 2)^2 = d^2 + 4d + 4
                        d_next  = d_reg + VW'(2);
                        sq_next = sq_reg + {d_reg, 2'b00} + SW'(4);
                    end
                    state_next = ST_CHECK;
                end
            end
            ST_FINISH:
            begin
                if (rem_reg > VW'(1))
                begin
                    if (pend_valid_reg)
                    begin
                        valid_next    = 1'b1;
                        factor_next   = NUMBER_W'(pend_reg);
                        position_next = count_reg;
                        last_next     = 1'b0;
                        count_next    = count_reg + POSITION_W'(1);
                    end
                    pend_next       = rem_reg;
                    pend_valid_next = 1'b1;
                    rem_next        = VW'(1);
                end
                state_next = ST_LAST;
            end
            ST_LAST:
            begin
                valid_next    = 1'b1;
                position_next = count_reg;
                if (count_reg == '0)
                begin
                    // prime input: lead with 1
                    factor_next = NUMBER_W'(1);
                    last_next   = 1'b0;
                    count_next  = POSITION_W'(1);
                end
                else
                begin
                    factor_next     = NUMBER_W'(pend_reg);
                    last_next       = 1'b1;
                    pend_valid_next = 1'b0;
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            rem_reg        <= '0;
            d_reg          <= VW'(2);
            sq_reg         <= SW'(4);
            pend_valid_reg <= 1'b0;
            count_reg      <= '0;
            valid_reg      <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            rem_reg        <= rem_next;
            d_reg          <= d_next;
            sq_reg         <= sq_next;
            pend_valid_reg <= pend_valid_next;
            count_reg      <= count_next;
            valid_reg      <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_reg     <= pend_next;
        factor_reg   <= factor_next;
        position_reg <= position_next;
        last_reg     <= last_next;
    end

    assign busy     = (state_reg != ST_IDLE);
    assign valid    = valid_reg;
    assign factor   = factor_reg;
    assign position = position_reg;
    assign last     = last_reg;

`ifndef SYNTH
    a_result_follows_work: assert property (@(posedge clk) disable iff (!rst_n)
        valid |-> $past(busy))
        else $error("result without an item in progress");

    a_last_ends_item: assert property (@(posedge clk) disable iff (!rst_n)
        valid && last |-> !busy)
        else $error("final result while item still in progress");

    a_divisor_floor: assert property (@(posedge clk) disable iff (!rst_n)
        busy |-> (d_reg >= VW'(2)))
        else $error("trial divisor below two");

    a_divider_idle_start: assert property (@(posedge clk) disable iff (!rst_n)
        div_start |=> (state_reg == ST_DIVIDE))
        else $error("divider launched outside the divide step");
`endif

endmodule

`default_nettype wire
